/* src/assert_macros.svh */
// Assertion macros shared by the evaluator RTL, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define DEE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evaluator assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define DEE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evaluator assertion failed");

`else

`define DEE_ASSERT_IMP(lbl, ante, cons)
`define DEE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* src/dee_pkg.sv */
// Package of types, codes and the reduction function of the digit expression evaluator.
`default_nettype none

package dee_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [1:0]             opc_t;
  typedef logic [1:0]             status_t;
  typedef logic [1:0]             sel_t;
  typedef logic [2:0]             act_t;

  localparam cnt_t DEPTH_CNT = CNT_W'(STACK_DEPTH);

  // Operator stack entry codes.
  localparam opc_t OP_PLUS  = 2'd0;
  localparam opc_t OP_MINUS = 2'd1;
  localparam opc_t OP_OTHER = 2'd2;
  localparam opc_t OP_OPEN  = 2'd3;

  // Result status codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_MISSING  = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;
  localparam status_t ST_BRACKET  = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;

  // Per-cell source select: keep, take from the neighbor nearer the top,
  // take from the neighbor below, or take from two below.
  localparam sel_t SEL_HOLD = 2'd0;
  localparam sel_t SEL_UP   = 2'd1;
  localparam sel_t SEL_DN   = 2'd2;
  localparam sel_t SEL_DN2  = 2'd3;

  // Stack actions for one transaction. On the operand stack, ACT_PUSH, ACT_REPL and
  // ACT_POP1 write a new top value; ACT_POP1 then also lifts the entries below.
  localparam act_t ACT_HOLD = 3'd0;
  localparam act_t ACT_PUSH = 3'd1;
  localparam act_t ACT_REPL = 3'd2;
  localparam act_t ACT_POP1 = 3'd3;
  localparam act_t ACT_POP2 = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] result_value;
    status_t                       status;
  } out_t;

  // Stack tops captured on the last character for the final drain.
  typedef struct packed {
    opc_t    op_top;
    cnt_t    pc;
    cnt_t    oc;
    value_t  s0;
    value_t  s1;
    status_t err;
  } fin_t;

  function automatic value_t dee_alu(input opc_t op, input value_t a, input value_t b);
    value_t r;
    r = '0;
    case (op)
      OP_PLUS:  r = a + b;
      OP_MINUS: r = b - a;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/dee_operand_cell.sv */
// One entry of the operand stack shift chain.
`default_nettype none

module dee_operand_cell (
  input  wire              clk,
  input  dee_pkg::sel_t    sel,
  input  dee_pkg::value_t  up_val,
  input  dee_pkg::value_t  dn_val,
  output dee_pkg::value_t  val_r,
  output dee_pkg::value_t  val_nxt
);

  always_comb begin
    case (sel)
      dee_pkg::SEL_UP: val_nxt = up_val;
      dee_pkg::SEL_DN: val_nxt = dn_val;
      default:         val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

/* src/dee_operator_cell.sv */
// One entry of the operator stack shift chain.
`default_nettype none

module dee_operator_cell (
  input  wire            clk,
  input  dee_pkg::sel_t  sel,
  input  dee_pkg::opc_t  up_val,
  input  dee_pkg::opc_t  dn_val,
  input  dee_pkg::opc_t  dn2_val,
  output dee_pkg::opc_t  val_r,
  output dee_pkg::opc_t  val_nxt
);

  always_comb begin
    case (sel)
      dee_pkg::SEL_UP:  val_nxt = up_val;
      dee_pkg::SEL_DN:  val_nxt = dn_val;
      dee_pkg::SEL_DN2: val_nxt = dn2_val;
      default:          val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

/* src/digit_expression_evaluator_unit.sv */
// Top level of the digit expression evaluator: two shift-chain stacks and a drain stage.
// Throughput: one character per cycle, back to back, each decided against the stack tops in
// cells 0 and 1 with at most one reduction; the input stalls only while both result registers
// are full and out_stall is high. The edge accepting the last character fills the drain
// register, whose result loads the output register once that is empty or out_stall is low.
// Reset (rst_n low, synchronous) empties both stacks, clears the status and drops any result.
`default_nettype none
`include "assert_macros.svh"

module digit_expression_evaluator_unit (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  input  dee_pkg::in_t  in_data,
  output logic          out_valid,
  input  wire           out_stall,
  output dee_pkg::out_t out_data
);

  // Stack occupancy and the sticky error of the expression in progress.
  dee_pkg::cnt_t    oc_r, oc_nxt, oc_c;
  dee_pkg::cnt_t    pc_r, pc_nxt, pc_c;
  dee_pkg::status_t err_r, err_nxt, err_c;

  // Cell outputs of both chains. Cell 0 is the top of each stack.
  dee_pkg::value_t opnd_q [dee_pkg::STACK_DEPTH];
  dee_pkg::value_t opnd_n [dee_pkg::STACK_DEPTH];
  dee_pkg::opc_t   oper_q [dee_pkg::STACK_DEPTH];
  dee_pkg::opc_t   oper_n [dee_pkg::STACK_DEPTH];

  // Drain stage and output register.
  dee_pkg::fin_t fin_r;
  logic          fin_valid_r, fin_valid_nxt;
  dee_pkg::out_t out_data_r, out_data_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic accept;
  logic fin_adv;

  // Character classification.
  logic is_open, is_close, is_digit, red_en;
  dee_pkg::value_t digit_val, red_a, red_b, red_r;
  dee_pkg::opc_t   op_code;

  // Stack actions for this cycle, and the values written at the tops.
  dee_pkg::act_t   opnd_act, oper_act;
  dee_pkg::value_t opnd_new;
  dee_pkg::opc_t   oper_new;
  dee_pkg::cnt_t   pc_mid;
  dee_pkg::sel_t   opnd_sel_top, opnd_sel_body, oper_sel_top, oper_sel_body;

  // Final drain signals.
  logic             f_red;
  dee_pkg::value_t  f_a, f_b, f_r, f_val;
  dee_pkg::status_t f_err;
  dee_pkg::cnt_t    f_pcm;

  // ---------------------------------------------------------------------------
  // Handshake. The drain register is the skid point: a new transaction is
  // taken whenever that register is empty or about to move into the output
  // register, so characters keep streaming while a result waits downstream.
  // ---------------------------------------------------------------------------
  assign fin_adv  = fin_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = fin_valid_r && !fin_adv;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Per-transaction decode. Every bracket segment of the operator stack holds
  // at most one pending operator, so a single reduction with the two top
  // operands finishes the work of one character.
  // ---------------------------------------------------------------------------
  always_comb begin
    is_open  = (in_data.char_code == dee_pkg::CH_LPAREN) ||
               (in_data.char_code == dee_pkg::CH_LBRACK) ||
               (in_data.char_code == dee_pkg::CH_LBRACE);
    is_close = (in_data.char_code == dee_pkg::CH_RPAREN) ||
               (in_data.char_code == dee_pkg::CH_RBRACK) ||
               (in_data.char_code == dee_pkg::CH_RBRACE);
    is_digit = (in_data.char_code >= dee_pkg::CH_ZERO) &&
               (in_data.char_code <= dee_pkg::CH_NINE);
    digit_val = dee_pkg::VALUE_WIDTH'(in_data.char_code - dee_pkg::CH_ZERO);

    if (in_data.char_code == dee_pkg::CH_PLUS) begin
      op_code = dee_pkg::OP_PLUS;
    end else if (in_data.char_code == dee_pkg::CH_MINUS) begin
      op_code = dee_pkg::OP_MINUS;
    end else begin
      op_code = dee_pkg::OP_OTHER;
    end

    // A close bracket or any operator reduces the pending operator, if the
    // top of the operator stack holds one rather than an open bracket.
    red_en = !is_open && !is_digit && (pc_r != '0) && (oper_q[0] != dee_pkg::OP_OPEN);
    red_a  = (oc_r != '0) ? opnd_q[0] : '0;
    red_b  = (oc_r >= dee_pkg::CNT_W'(2)) ? opnd_q[1] : '0;
    red_r  = dee_pkg::dee_alu(oper_q[0], red_a, red_b);
  end

  always_comb begin
    err_c    = err_r;
    oc_c     = oc_r;
    pc_c     = pc_r;
    opnd_act = dee_pkg::ACT_HOLD;
    opnd_new = digit_val;
    oper_act = dee_pkg::ACT_HOLD;
    oper_new = dee_pkg::OP_OPEN;
    pc_mid   = pc_r - dee_pkg::CNT_W'(red_en);

    if (is_open) begin
      if (pc_r < dee_pkg::DEPTH_CNT) begin
        oper_act = dee_pkg::ACT_PUSH;
        pc_c     = pc_r + dee_pkg::CNT_W'(1);
      end else if (err_c == dee_pkg::ST_OK) begin
        err_c = dee_pkg::ST_OVERFLOW;
      end
    end else if (is_digit) begin
      if (oc_r < dee_pkg::DEPTH_CNT) begin
        opnd_act = dee_pkg::ACT_PUSH;
        oc_c     = oc_r + dee_pkg::CNT_W'(1);
      end else if (err_c == dee_pkg::ST_OK) begin
        err_c = dee_pkg::ST_OVERFLOW;
      end
    end else begin
      if (red_en) begin
        // Missing operands read as zero; the ones present are consumed.
        opnd_new = red_r;
        if ((oc_r < dee_pkg::CNT_W'(2)) && (err_c == dee_pkg::ST_OK)) begin
          err_c = dee_pkg::ST_MISSING;
        end
        if (oc_r >= dee_pkg::CNT_W'(2)) begin
          opnd_act = dee_pkg::ACT_POP1;
          oc_c     = oc_r - dee_pkg::CNT_W'(1);
        end else if (oc_r != '0) begin
          opnd_act = dee_pkg::ACT_REPL;
        end else begin
          opnd_act = dee_pkg::ACT_PUSH;
          oc_c     = dee_pkg::CNT_W'(1);
        end
      end

      if (is_close) begin
        if (pc_mid != '0) begin
          oper_act = red_en ? dee_pkg::ACT_POP2 : dee_pkg::ACT_POP1;
          pc_c     = pc_mid - dee_pkg::CNT_W'(1);
        end else begin
          if (err_c == dee_pkg::ST_OK) begin
            err_c = dee_pkg::ST_BRACKET;
          end
          oper_act = red_en ? dee_pkg::ACT_POP1 : dee_pkg::ACT_HOLD;
          pc_c     = pc_mid;
        end
      end else begin
        oper_new = op_code;
        if (red_en) begin
          // The reduced operator's slot takes the new one.
          oper_act = dee_pkg::ACT_REPL;
        end else if (pc_r < dee_pkg::DEPTH_CNT) begin
          oper_act = dee_pkg::ACT_PUSH;
          pc_c     = pc_r + dee_pkg::CNT_W'(1);
        end else if (err_c == dee_pkg::ST_OK) begin
          err_c = dee_pkg::ST_OVERFLOW;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Action to cell selects. The top cell takes the new value on a push or replace, and
  // the operand top also on a pop; the cells below shift as one chain.
  // ---------------------------------------------------------------------------
  always_comb begin
    opnd_sel_top  = dee_pkg::SEL_HOLD;
    opnd_sel_body = dee_pkg::SEL_HOLD;
    oper_sel_top  = dee_pkg::SEL_HOLD;
    oper_sel_body = dee_pkg::SEL_HOLD;
    if (accept) begin
      unique case (opnd_act) inside
        dee_pkg::ACT_PUSH: begin
          opnd_sel_top  = dee_pkg::SEL_UP;
          opnd_sel_body = dee_pkg::SEL_UP;
        end
        dee_pkg::ACT_REPL: begin
          opnd_sel_top = dee_pkg::SEL_UP;
        end
        dee_pkg::ACT_POP1: begin
          opnd_sel_top  = dee_pkg::SEL_UP;
          opnd_sel_body = dee_pkg::SEL_DN;
        end
        default: begin
          opnd_sel_top  = dee_pkg::SEL_HOLD;
          opnd_sel_body = dee_pkg::SEL_HOLD;
        end
      endcase
      unique case (oper_act) inside
        dee_pkg::ACT_PUSH: begin
          oper_sel_top  = dee_pkg::SEL_UP;
          oper_sel_body = dee_pkg::SEL_UP;
        end
        dee_pkg::ACT_REPL: begin
          oper_sel_top = dee_pkg::SEL_UP;
        end
        dee_pkg::ACT_POP1: begin
          oper_sel_top  = dee_pkg::SEL_DN;
          oper_sel_body = dee_pkg::SEL_DN;
        end
        dee_pkg::ACT_POP2: begin
          oper_sel_top  = dee_pkg::SEL_DN2;
          oper_sel_body = dee_pkg::SEL_DN2;
        end
        default: begin
          oper_sel_top  = dee_pkg::SEL_HOLD;
          oper_sel_body = dee_pkg::SEL_HOLD;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // The two stacks as chains of cells.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < dee_pkg::STACK_DEPTH; i++) begin : g_cell
    dee_pkg::value_t opnd_up, opnd_dn;
    dee_pkg::opc_t   oper_up, oper_dn, oper_dn2;
    dee_pkg::sel_t   opnd_sel, oper_sel;

    if (i == 0) begin : g_top
      assign opnd_up  = opnd_new;
      assign oper_up  = oper_new;
      assign opnd_sel = opnd_sel_top;
      assign oper_sel = oper_sel_top;
    end else begin : g_body
      assign opnd_up  = opnd_q[i-1];
      assign oper_up  = oper_q[i-1];
      assign opnd_sel = opnd_sel_body;
      assign oper_sel = oper_sel_body;
    end

    if (i + 1 < dee_pkg::STACK_DEPTH) begin : g_dn
      assign opnd_dn = opnd_q[i+1];
      assign oper_dn = oper_q[i+1];
    end else begin : g_dn_end
      assign opnd_dn = '0;
      assign oper_dn = dee_pkg::OP_OPEN;
    end

    if (i + 2 < dee_pkg::STACK_DEPTH) begin : g_dn2
      assign oper_dn2 = oper_q[i+2];
    end else begin : g_dn2_end
      assign oper_dn2 = dee_pkg::OP_OPEN;
    end

    dee_operand_cell u_opnd (
      .clk     (clk),
      .sel     (opnd_sel),
      .up_val  (opnd_up),
      .dn_val  (opnd_dn),
      .val_r   (opnd_q[i]),
      .val_nxt (opnd_n[i])
    );

    dee_operator_cell u_oper (
      .clk     (clk),
      .sel     (oper_sel),
      .up_val  (oper_up),
      .dn_val  (oper_dn),
      .dn2_val (oper_dn2),
      .val_r   (oper_q[i]),
      .val_nxt (oper_n[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Counters and status. The last character of an expression empties both
  // stacks at once; its tops travel on to the drain register instead.
  // ---------------------------------------------------------------------------
  always_comb begin
    oc_nxt  = oc_r;
    pc_nxt  = pc_r;
    err_nxt = err_r;
    if (accept) begin
      if (in_data.is_last) begin
        oc_nxt  = '0;
        pc_nxt  = '0;
        err_nxt = dee_pkg::ST_OK;
      end else begin
        oc_nxt  = oc_c;
        pc_nxt  = pc_c;
        err_nxt = err_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final drain: reduce the last pending operator, flagging a missing operand, flag an
  // unclosed bracket, and pick the top operand (zero for an empty stack).
  // ---------------------------------------------------------------------------
  always_comb begin
    f_red = (fin_r.pc != '0) && (fin_r.op_top != dee_pkg::OP_OPEN);
    f_a   = (fin_r.oc != '0) ? fin_r.s0 : '0;
    f_b   = (fin_r.oc >= dee_pkg::CNT_W'(2)) ? fin_r.s1 : '0;
    f_r   = dee_pkg::dee_alu(fin_r.op_top, f_a, f_b);
    f_err = fin_r.err;
    if (f_red && (fin_r.oc < dee_pkg::CNT_W'(2)) && (f_err == dee_pkg::ST_OK)) begin
      f_err = dee_pkg::ST_MISSING;
    end
    f_pcm = fin_r.pc - dee_pkg::CNT_W'(f_red);
    if ((f_pcm != '0) && (f_err == dee_pkg::ST_OK)) begin
      f_err = dee_pkg::ST_BRACKET;
    end
    if (f_red) begin
      f_val = f_r;
    end else if (fin_r.oc != '0) begin
      f_val = fin_r.s0;
    end else begin
      f_val = '0;
    end
    out_data_nxt.result_value = f_val;
    out_data_nxt.status       = f_err;
  end

  always_comb begin
    fin_valid_nxt = fin_valid_r;
    if (accept && in_data.is_last) begin
      fin_valid_nxt = 1'b1;
    end else if (fin_adv) begin
      fin_valid_nxt = 1'b0;
    end
    out_valid_nxt = (out_valid_r && out_stall) || fin_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r        <= '0;
      pc_r        <= '0;
      err_r       <= dee_pkg::ST_OK;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      oc_r        <= oc_nxt;
      pc_r        <= pc_nxt;
      err_r       <= err_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the drain and output stages.
  always_ff @(posedge clk) begin
    if (accept && in_data.is_last) begin
      fin_r.op_top <= oper_n[0];
      fin_r.pc     <= pc_c;
      fin_r.oc     <= oc_c;
      fin_r.s0     <= opnd_n[0];
      fin_r.s1     <= opnd_n[1];
      fin_r.err    <= err_c;
    end
    if (fin_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `DEE_ASSERT_IMP(a_cnt_range, 1'b1, (oc_r <= dee_pkg::DEPTH_CNT) && (pc_r <= dee_pkg::DEPTH_CNT))
  `DEE_ASSERT_NXT(a_last_clears, accept && in_data.is_last, fin_valid_r && (oc_r == '0) && (pc_r == '0) && (err_r == dee_pkg::ST_OK))
  `DEE_ASSERT_NXT(a_fin_holds, fin_valid_r && !fin_adv, fin_valid_r && $stable(fin_r))
  `DEE_ASSERT_NXT(a_fin_to_out, fin_adv, out_valid_r)

endmodule

`default_nettype wire

/* tb/digit_expression_evaluator_unit_test.sv */
// Self-checking testbench for the digit expression evaluator unit.
module digit_expression_evaluator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dee_pkg::*;

  typedef logic [7:0] chars_t[$];

  // Extra cycles waited once the last expected result has been delivered.
  localparam int DRAIN_CYCLES = 8;
  // Length of the long receiver hold-off used to back the block up.
  localparam int HOLD_CYCLES  = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  digit_expression_evaluator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Idle rates in percent for the two sides, set before each group of tests.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long hold-off request: the test flips hold_trigger, the stall process notices
  // the change and keeps out_stall high while it counts hold_left down from HOLD_CYCLES.
  logic hold_trigger = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  // Shadow copy of the evaluator: both stacks, their depths and the sticky status
  // of the expression that is being read in.
  value_t  operand_mem [STACK_DEPTH];
  opc_t    operator_mem [STACK_DEPTH];
  int      operand_depth = 0;
  int      operator_depth = 0;
  status_t expr_status = ST_OK;

  // Results that the accepted expressions must still produce, oldest first.
  out_t expr_results_due[$];
  out_t due_result;

  int mismatch_count = 0;
  int chars_accepted = 0;
  int results_checked = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Shadow evaluator
  // ---------------------------------------------------------------------------

  // Only the first error of an expression is kept.
  function automatic void note_error(status_t code);
    if (expr_status == ST_OK) expr_status = code;
  endfunction

  // A push onto a full stack is dropped and flags an overflow.
  function automatic void push_value(value_t v);
    if (operand_depth >= STACK_DEPTH) begin
      note_error(ST_OVERFLOW);
    end else begin
      operand_mem[operand_depth] = v;
      operand_depth++;
    end
  endfunction

  function automatic void push_op(opc_t op);
    if (operator_depth >= STACK_DEPTH) begin
      note_error(ST_OVERFLOW);
    end else begin
      operator_mem[operator_depth] = op;
      operator_depth++;
    end
  endfunction

  // An operand that is not there reads as zero and flags a missing operand.
  function automatic value_t pop_value();
    if (operand_depth == 0) begin
      note_error(ST_MISSING);
      return '0;
    end
    operand_depth--;
    return operand_mem[operand_depth];
  endfunction

  // Apply every operator above the nearest open bracket; arithmetic wraps at the
  // value width because everything is held in value_t.
  function automatic void reduce_to_bracket();
    opc_t   op;
    value_t a;
    value_t b;
    value_t r;
    while (operator_depth > 0 && operator_mem[operator_depth - 1] != OP_OPEN) begin
      op = operator_mem[operator_depth - 1];
      operator_depth--;
      a = pop_value();
      b = pop_value();
      case (op)
        OP_PLUS:  r = a + b;
        OP_MINUS: r = b - a;
        default:  r = '0;
      endcase
      push_value(r);
    end
  endfunction

  // Work out the effect of one accepted character; the last character of an
  // expression queues the result that the block has to deliver.
  function automatic void evaluate_char(in_t item);
    logic [7:0] c;
    out_t       res;
    c = item.char_code;
    if (c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE) begin
      push_op(OP_OPEN);
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      push_value(value_t'(c - CH_ZERO));
    end else if (c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE) begin
      reduce_to_bracket();
      if (operator_depth > 0) operator_depth--;
      else note_error(ST_BRACKET);
    end else begin
      reduce_to_bracket();
      if (c == CH_PLUS) push_op(OP_PLUS);
      else if (c == CH_MINUS) push_op(OP_MINUS);
      else push_op(OP_OTHER);
    end

    if (item.is_last) begin
      reduce_to_bracket();
      // A bracket still open after the final drain was never closed.
      if (operator_depth > 0) note_error(ST_BRACKET);
      res.result_value = (operand_depth > 0) ? operand_mem[operand_depth - 1] : '0;
      res.status = expr_status;
      expr_results_due = {expr_results_due, res};
      operand_depth = 0;
      operator_depth = 0;
      expr_status = ST_OK;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Character generators
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] open_char();
    case ($urandom_range(2))
      0:       return CH_LPAREN;
      1:       return CH_LBRACK;
      default: return CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] close_char();
    case ($urandom_range(2))
      0:       return CH_RPAREN;
      1:       return CH_RBRACK;
      default: return CH_RBRACE;
    endcase
  endfunction

  function automatic chars_t text_chars(string s);
    chars_t q;
    for (int i = 0; i < s.len(); i++) q = {q, s[i]};
    return q;
  endfunction

  // One random expression. Most are well formed with random digits, operators and
  // brackets of all three shapes; a few push one of the stacks near or past its
  // depth, and about a fifth of the well-formed ones are corrupted with random
  // bytes, stray brackets or dropped characters.
  function automatic chars_t random_expr();
    chars_t     q;
    logic [7:0] c;
    int         tokens;
    int         depth;
    int         depth_cap;
    int         shape;
    int         spot;
    bit         want_operand;
    shape = $urandom_range(99);
    if (shape < 3) begin
      repeat ($urandom_range(STACK_DEPTH + 3, STACK_DEPTH - 2)) q = {q, digit_char()};
    end else if (shape < 6) begin
      repeat ($urandom_range(STACK_DEPTH + 3, STACK_DEPTH - 2)) q = {q, open_char()};
      q = {q, digit_char()};
      repeat ($urandom_range(STACK_DEPTH + 3)) q = {q, close_char()};
    end else begin
      tokens = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(11, 1);
      depth_cap = $urandom_range(STACK_DEPTH / 2, 1);
      depth = 0;
      want_operand = 1'b1;
      repeat (tokens) begin
        if (want_operand) begin
          if (depth < depth_cap && $urandom_range(3) == 0) begin
            q = {q, open_char()};
            depth++;
          end else begin
            q = {q, digit_char()};
            want_operand = 1'b0;
          end
        end else if (depth > 0 && $urandom_range(2) == 0) begin
          q = {q, close_char()};
          depth--;
        end else begin
          shape = $urandom_range(19);
          if (shape < 9) begin
            c = CH_PLUS;
          end else if (shape < 18) begin
            c = CH_MINUS;
          end else begin
            // Any byte that is neither a digit nor a bracket acts as an operator.
            do c = 8'($urandom_range(255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_LPAREN || c == CH_RPAREN ||
                   c == CH_LBRACK || c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE);
          end
          q = {q, c};
          want_operand = 1'b1;
        end
      end
      if (want_operand) q = {q, digit_char()};
      repeat (depth) q = {q, close_char()};

      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          spot = $urandom_range(q.size() - 1);
          case ($urandom_range(3))
            0:       q[spot] = 8'($urandom_range(255));
            1:       q.insert(spot, 8'($urandom_range(255)));
            2:       q.insert(spot, $urandom_range(1) ? open_char() : close_char());
            default: if (q.size() > 1) q.delete(spot);
          endcase
        end
      end
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one character and hold it until the transaction is accepted. Valid is
  // left high afterwards so back-to-back characters need no second assignment in
  // the same step; an idle gap, when one is drawn, lowers it first.
  task automatic send_char(input logic [7:0] c, input logic last);
    in_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.char_code = c;
    item.is_last = last;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_accepted++;
    evaluate_char(item);
  endtask

  task automatic send_expr(input chars_t chars);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // Stop offering and wait until every queued result has been delivered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expr_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, or solidly during a requested hold-off.
  always @(posedge clk) begin
    if (hold_trigger != hold_ack) begin
      hold_ack <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every result transaction is matched against the oldest expected result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expr_results_due.size() == 0) begin
        $display("%0t: result with none expected: result_value %0d status %0d",
                 $time, out_data.result_value, out_data.status);
        mismatch_count++;
      end else begin
        due_result = expr_results_due.pop_front();
        if (out_data.result_value !== due_result.result_value) begin
          $display("%0t: result_value expected %0d got %0d",
                   $time, due_result.result_value, out_data.result_value);
          mismatch_count++;
        end
        if (out_data.status !== due_result.status) begin
          $display("%0t: status expected %0d got %0d",
                   $time, due_result.status, out_data.status);
          mismatch_count++;
        end
        status_seen[due_result.status]++;
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All six bracket shapes, digits 0 and 9, plus and minus:
  // { 9 + ( 0 ] - [ 8 ) } evaluates left to right to 1.
  task automatic test_brackets_and_arithmetic();
    send_expr(text_chars("{9+(0]-[8)}"));
    drain_results();
  endtask

  // A close bracket with nothing open, and an open bracket left unclosed behind
  // an operand that still comes out as the result.
  task automatic test_bracket_errors();
    send_expr(text_chars(")"));
    send_expr(text_chars("(5"));
    drain_results();
  endtask

  // A leading minus reduces against an absent operand, giving a negative value.
  // The lowest and highest bytes act as operators that yield zero and leave the
  // final drain one operand short.
  task automatic test_missing_operand();
    chars_t q;
    send_expr(text_chars("-5"));
    q = '{CH_ZERO + 8'd8, 8'hFF, CH_ZERO + 8'd5, 8'h00};
    send_expr(q);
    drain_results();
  endtask

  // One digit more than the operand stack holds: the last push is dropped.
  task automatic test_stack_overflow();
    chars_t q;
    for (int i = 0; i <= STACK_DEPTH; i++) q = {q, CH_ZERO + 8'(i % 10)};
    send_expr(q);
    drain_results();
  endtask

  task automatic test_random_expressions(input int sender_pct, input int receiver_pct,
                                         input int char_budget);
    int start;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start = chars_accepted;
    while (chars_accepted - start < char_budget) send_expr(random_expr());
    drain_results();
  endtask

  // The receiver holds off for a long stretch while characters keep coming at
  // full rate, so results pile up and the block has to stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger <= ~hold_trigger;
    repeat (12) send_expr(random_expr());
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 50;
    test_brackets_and_arithmetic();
    test_bracket_errors();
    test_missing_operand();
    test_stack_overflow();

    test_random_expressions(15, 50, 400);
    test_random_expressions(50, 15, 400);
    test_random_expressions(0, 0, 400);
    test_output_backpressure();

    $display("Evaluated %0d expressions from %0d characters, with brackets, stack floods",
             results_checked, chars_accepted);
    $display("and corrupted input: %0d ok, %0d missing operand, %0d overflow, %0d bracket",
             status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_OVERFLOW],
             status_seen[ST_BRACKET]);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net in case the block stops answering.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, expr_results_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
